>>> design/spac_pkg.sv
// Package: screen size, configuration register indexes and pipeline stage types.
package spac_pkg;

  localparam int unsigned SCREEN_WIDTH  = 320;
  localparam int unsigned SCREEN_HEIGHT = 240;

  // Screen bounds as 17-bit signed values for the position compares.
  localparam logic signed [16:0] ScrWidthS  = 17'(SCREEN_WIDTH);
  localparam logic signed [16:0] ScrHeightS = 17'(SCREEN_HEIGHT);

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SPRITE_POS_X  = 3'd0,
    CFG_SPRITE_POS_Y  = 3'd1,
    CFG_VIEW_OFFSET_X = 3'd2,
    CFG_VIEW_OFFSET_Y = 3'd3,
    CFG_SPRITE_WIDTH  = 3'd4,
    CFG_SPRITE_HEIGHT = 3'd5,
    CFG_OPACITY       = 3'd6,
    CFG_BLEND_ENABLE  = 3'd7
  } cfg_reg_e;

  localparam logic [7:0] OpaqueAlpha = 8'd255;

  // Stage 1: texel fields, camera-adjusted sprite origin and early decisions.
  typedef struct packed {
    logic [7:0]         lx;
    logic [7:0]         ly;
    logic [15:0]        fg;
    logic [15:0]        bg;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic               ok;
    logic               blend;
  } spac_s1_t;

  // Stage 2: final write decision, position and channel products.
  typedef struct packed {
    logic        we;
    logic [8:0]  col;
    logic [7:0]  row;
    logic [15:0] fg;
    logic        blend;
    logic [12:0] r_fg;
    logic [12:0] r_bg;
    logic [13:0] g_fg;
    logic [13:0] g_bg;
    logic [12:0] b_fg;
    logic [12:0] b_bg;
  } spac_s2_t;

endpackage

>>> design/sprite_pixel_alpha_compositor_core.sv
// Sprite pixel compositor: clipping and RGB565 alpha blending in a three-stage pipeline.
//
//  Channel   Signals                                           Direction
//  -------   -----------------------------------------------   ---------
//  request   in_valid_i/in_ready_o, local_x/y, texel/backdrop  input
//  result    out_valid_o/out_ready_i, write_enable, col/row,   output
//            out_color
//  config    cfg_wr_en_i, cfg_idx_i, cfg_data_i                input
//
// Every request gives exactly one result after passing the three registered stages.
// A new request is taken in every cycle unless a stall holds the pipeline, and the
// channel multipliers all sit in the middle stage.
// The whole pipeline advances together whenever the result register is empty
// or its result is being taken, so a stall freezes every stage in place.
// Reset clears the stage valid bits and loads the register reset values;
// there is no clearing pass.
module sprite_pixel_alpha_compositor_core
  import spac_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration writes
  input  logic                cfg_wr_en_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // Request channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          local_x_i,
  input  logic [7:0]          local_y_i,
  input  logic [15:0]         texel_color_i,
  input  logic [15:0]         backdrop_color_i,
  // Result channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                write_enable_o,
  output logic [8:0]          screen_col_o,
  output logic [7:0]          screen_row_o,
  output logic [15:0]         out_color_o
);

  // Configuration registers. The user must change them only while the pipeline is
  // empty (the block does not enforce this), so every stage reads them directly.
  logic [15:0] pos_x_q, pos_y_q, view_x_q, view_y_q;
  logic [7:0]  width_q, height_q, opacity_q;
  logic        blend_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q    <= '0;
      pos_y_q    <= '0;
      view_x_q   <= '0;
      view_y_q   <= '0;
      width_q    <= '0;
      height_q   <= '0;
      opacity_q  <= OpaqueAlpha;
      blend_en_q <= 1'b0;
    end else if (cfg_wr_en_i) begin
      case (cfg_idx_i)
        CFG_SPRITE_POS_X:  pos_x_q    <= cfg_data_i;
        CFG_SPRITE_POS_Y:  pos_y_q    <= cfg_data_i;
        CFG_VIEW_OFFSET_X: view_x_q   <= cfg_data_i;
        CFG_VIEW_OFFSET_Y: view_y_q   <= cfg_data_i;
        CFG_SPRITE_WIDTH:  width_q    <= cfg_data_i[7:0];
        CFG_SPRITE_HEIGHT: height_q   <= cfg_data_i[7:0];
        CFG_OPACITY:       opacity_q  <= cfg_data_i[7:0];
        CFG_BLEND_ENABLE:  blend_en_q <= cfg_data_i[0];
        default:           ;
      endcase
    end
  end

  // Global advance: all stages move when the result register can take a value.
  logic adv;
  logic s1_valid_q, s2_valid_q, out_valid_q;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= in_valid_i;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: the sprite is rejected when its world origin lies beyond the screen
  // bounds, widened by its size at the left and top; the camera-relative origin
  // wraps to 16 bits. A black texel is dropped when the sprite is opaque.
  // ---------------------------------------------------------------------------
  spac_s1_t           s1_d, s1_q;
  logic signed [16:0] px_ext, py_ext, neg_w, neg_h;
  logic               off_screen;

  always_comb begin
    px_ext     = {pos_x_q[15], pos_x_q};
    py_ext     = {pos_y_q[15], pos_y_q};
    neg_w      = -$signed({9'b0, width_q});
    neg_h      = -$signed({9'b0, height_q});
    off_screen = (px_ext < neg_w) || (px_ext > ScrWidthS) ||
                 (py_ext < neg_h) || (py_ext > ScrHeightS);

    s1_d.lx    = local_x_i;
    s1_d.ly    = local_y_i;
    s1_d.fg    = texel_color_i;
    s1_d.bg    = backdrop_color_i;
    s1_d.sx    = $signed(pos_x_q - view_x_q);
    s1_d.sy    = $signed(pos_y_q - view_y_q);
    s1_d.ok    = !off_screen && (local_x_i < width_q) && (local_y_i < height_q) &&
                 !((texel_color_i == 16'd0) && (opacity_q == OpaqueAlpha));
    s1_d.blend = blend_en_q && (opacity_q != OpaqueAlpha);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= s1_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: screen position and display clip; per-channel products of the
  // texel with alpha and of the backdrop with its complement.
  // ---------------------------------------------------------------------------
  spac_s2_t           s2_d, s2_q;
  logic signed [16:0] col, row;
  logic [7:0]         inv_a;

  always_comb begin
    col   = {s1_q.sx[15], s1_q.sx} + $signed({9'b0, s1_q.lx});
    row   = {s1_q.sy[15], s1_q.sy} + $signed({9'b0, s1_q.ly});
    inv_a = OpaqueAlpha - opacity_q;

    s2_d.we    = s1_q.ok && (col >= 17'sd0) && (col < ScrWidthS) &&
                 (row >= 17'sd0) && (row < ScrHeightS);
    s2_d.col   = col[8:0];
    s2_d.row   = row[7:0];
    s2_d.fg    = s1_q.fg;
    s2_d.blend = s1_q.blend;
    s2_d.r_fg  = {8'b0, s1_q.fg[15:11]} * {5'b0, opacity_q};
    s2_d.r_bg  = {8'b0, s1_q.bg[15:11]} * {5'b0, inv_a};
    s2_d.g_fg  = {8'b0, s1_q.fg[10:5]}  * {6'b0, opacity_q};
    s2_d.g_bg  = {8'b0, s1_q.bg[10:5]}  * {6'b0, inv_a};
    s2_d.b_fg  = {8'b0, s1_q.fg[4:0]}   * {5'b0, opacity_q};
    s2_d.b_bg  = {8'b0, s1_q.bg[4:0]}   * {5'b0, inv_a};
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_q <= s2_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: blend by summing the products and keeping each channel's top bits,
  // else pass the texel; zero the whole result when the pixel is not written.
  // ---------------------------------------------------------------------------
  logic [13:0] r_sum, b_sum;
  logic [14:0] g_sum;
  logic [15:0] color;
  logic        we_q;
  logic [8:0]  col_q;
  logic [7:0]  row_q;
  logic [15:0] color_q;

  always_comb begin
    r_sum = {1'b0, s2_q.r_fg} + {1'b0, s2_q.r_bg};
    g_sum = {1'b0, s2_q.g_fg} + {1'b0, s2_q.g_bg};
    b_sum = {1'b0, s2_q.b_fg} + {1'b0, s2_q.b_bg};
    color = s2_q.blend ? {r_sum[12:8], g_sum[13:8], b_sum[12:8]} : s2_q.fg;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      we_q    <= s2_q.we;
      col_q   <= s2_q.we ? s2_q.col : 9'd0;
      row_q   <= s2_q.we ? s2_q.row : 8'd0;
      color_q <= s2_q.we ? color    : 16'd0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign write_enable_o = we_q;
  assign screen_col_o   = col_q;
  assign screen_row_o   = row_q;
  assign out_color_o    = color_q;

endmodule

>>> design/spac_checker.sv
// Port-level checker for the sprite compositor, bound to the top level.
module spac_checker
  import spac_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        write_enable_o,
  input logic [8:0]  screen_col_o,
  input logic [7:0]  screen_row_o,
  input logic [15:0] out_color_o
);

  // A held result keeps its value until taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(write_enable_o) &&
      $stable(screen_col_o) && $stable(screen_row_o) && $stable(out_color_o))
    else $error("stalled result changed");

  // With no result waiting, the pipeline must take a new request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("request refused while the result register is empty");

  // A pixel that is not written carries an all-zero result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !write_enable_o |->
      screen_col_o == 9'd0 && screen_row_o == 8'd0 && out_color_o == 16'd0)
    else $error("unwritten pixel has non-zero fields");

  // A written pixel lies on the display.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && write_enable_o |->
      (SCREEN_WIDTH > 512 || 32'(screen_col_o) < SCREEN_WIDTH) &&
      (SCREEN_HEIGHT > 256 || 32'(screen_row_o) < SCREEN_HEIGHT))
    else $error("written pixel outside the display");

  // A request accepted while the receiver keeps taking results yields a
  // result once it has run through the pipeline.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) ##1 out_ready_i [*2] |=> out_valid_o)
    else $error("result missing after an accepted request");

endmodule

bind sprite_pixel_alpha_compositor_core spac_checker u_spac_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .write_enable_o (write_enable_o),
  .screen_col_o   (screen_col_o),
  .screen_row_o   (screen_row_o),
  .out_color_o    (out_color_o)
);

>>> bench/sprite_pixel_alpha_compositor_core_tb.sv
// Self-checking testbench for the sprite pixel compositor: directed table, then paced random texels.
module sprite_pixel_alpha_compositor_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spac_pkg::*;

  // Screen bounds as plain signed integers, so that compares against
  // negative positions stay signed.
  localparam int ScrW = SCREEN_WIDTH;
  localparam int ScrH = SCREEN_HEIGHT;

  // Cycles with no request and no result taken before the run is declared hung.
  // The slowest correct pacing has the receiver refuse a result in most cycles,
  // and the longest deliberate pause is the drain wait and register update
  // between settings.
  localparam int StallLimit = 2000;

  // Cycles waited after the last expected result has been taken.
  localparam int DrainCycles = 6;

  // One complete register setting of the sprite.
  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] view_x;
    logic signed [15:0] view_y;
    logic [7:0]         width;
    logic [7:0]         height;
    logic [7:0]         alpha;
    logic               blend;
  } sprite_setting_t;

  // What the block should emit for one request.
  typedef struct packed {
    logic        we;
    logic [8:0]  col;
    logic [7:0]  row;
    logic [15:0] color;
  } pixel_write_t;

  // One row of the directed table. Where known is set, the expected pixel is
  // written out by hand; otherwise it comes from the predictor.
  typedef struct packed {
    logic [3:0]   setting;
    logic [7:0]   lx;
    logic [7:0]   ly;
    logic [15:0]  fg;
    logic [15:0]  bg;
    logic         known;
    pixel_write_t want;
  } texel_case_t;

  localparam pixel_write_t NoWrite = '0;

  // Settings used by the directed table. Entry 0 equals the reset values, so
  // the first rows run on the block straight out of reset without any write.
  localparam sprite_setting_t DirSettings [12] = '{
    // Reset values: zero-sized sprite, opaque, no blending.
    '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'd0, 8'd0, 8'd255, 1'b0},
    // Small opaque sprite well inside the screen.
    '{16'sd10, 16'sd20, 16'sd0, 16'sd0, 8'd16, 8'd16, 8'd255, 1'b0},
    // Sprite straddling the bottom right corner of the display.
    '{16'sd310, 16'sd230, 16'sd0, 16'sd0, 8'd32, 8'd32, 8'd255, 1'b0},
    // World x one pixel left of the rejection bound, although the camera
    // would bring it into view.
    '{-16'sd33, 16'sd5, -16'sd100, 16'sd0, 8'd32, 8'd8, 8'd255, 1'b0},
    // World x one pixel right of the screen, camera again bringing it into view.
    '{16'sd321, 16'sd5, 16'sd300, 16'sd0, 8'd8, 8'd8, 8'd255, 1'b0},
    // World position exactly on the right and bottom bounds: still accepted.
    '{16'sd320, 16'sd240, 16'sd300, 16'sd200, 8'd8, 8'd8, 8'd255, 1'b0},
    // Half transparency with blending.
    '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'd255, 8'd255, 8'd128, 1'b1},
    // Fully transparent blend: the backdrop wins, a black texel is still written.
    '{-16'sd8, -16'sd8, -16'sd16, -16'sd16, 8'd255, 8'd255, 8'd0, 1'b1},
    // Nearly opaque without blending: the texel is copied, black included.
    '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'd255, 8'd255, 8'd254, 1'b0},
    // Register extremes: far off screen to the left, camera at the opposite ends.
    '{-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768, 8'd255, 8'd255, 8'd255, 1'b1},
    // Camera so far away that the screen offset wraps round 16 bits.
    '{16'sd200, 16'sd100, -16'sd32700, -16'sd32700, 8'd255, 8'd255, 8'd255, 1'b0},
    // Sprite partly above and left of the screen, blended.
    '{16'sd5, 16'sd5, 16'sd10, 16'sd10, 8'd255, 8'd255, 8'd200, 1'b1}
  };

  localparam texel_case_t DirCases [25] = '{
    // Zero-sized sprite after reset: nothing is ever written.
    '{4'd0, 8'd0, 8'd0, 16'hFFFF, 16'h0000, 1'b1, NoWrite},
    '{4'd0, 8'd255, 8'd255, 16'h1234, 16'hFFFF, 1'b1, NoWrite},
    // Opaque copies at the sprite corners, clipping at its own size, black skipped.
    '{4'd1, 8'd0, 8'd0, 16'hF800, 16'h07FF, 1'b1, '{1'b1, 9'd10, 8'd20, 16'hF800}},
    '{4'd1, 8'd15, 8'd15, 16'h07E0, 16'hF81F, 1'b1, '{1'b1, 9'd25, 8'd35, 16'h07E0}},
    '{4'd1, 8'd16, 8'd0, 16'h001F, 16'h0000, 1'b1, NoWrite},
    '{4'd1, 8'd0, 8'd16, 16'h001F, 16'h0000, 1'b1, NoWrite},
    '{4'd1, 8'd3, 8'd3, 16'h0000, 16'hFFFF, 1'b1, NoWrite},
    // Last visible column and row, then one past each.
    '{4'd2, 8'd9, 8'd9, 16'hFFFF, 16'h0000, 1'b1, '{1'b1, 9'd319, 8'd239, 16'hFFFF}},
    '{4'd2, 8'd10, 8'd0, 16'hFFFF, 16'h0000, 1'b1, NoWrite},
    '{4'd2, 8'd0, 8'd10, 16'hFFFF, 16'h0000, 1'b1, NoWrite},
    // Rejected sprites, then one exactly on the bounds.
    '{4'd3, 8'd0, 8'd0, 16'hFFFF, 16'h0000, 1'b1, NoWrite},
    '{4'd4, 8'd0, 8'd0, 16'hFFFF, 16'h0000, 1'b1, NoWrite},
    '{4'd5, 8'd3, 8'd4, 16'h1234, 16'h0000, 1'b1, '{1'b1, 9'd23, 8'd44, 16'h1234}},
    // Blending, checked against the predictor.
    '{4'd6, 8'd0, 8'd0, 16'hFFFF, 16'h0000, 1'b0, NoWrite},
    '{4'd6, 8'd100, 8'd100, 16'h0000, 16'hFFFF, 1'b0, NoWrite},
    '{4'd6, 8'd200, 8'd50, 16'hA5A5, 16'h5A5A, 1'b0, NoWrite},
    '{4'd7, 8'd0, 8'd0, 16'hF800, 16'h07FF, 1'b0, NoWrite},
    '{4'd7, 8'd31, 8'd7, 16'h0000, 16'hFFFF, 1'b0, NoWrite},
    // Plain copy below full opacity writes black as well.
    '{4'd8, 8'd5, 8'd6, 16'h0000, 16'hFFFF, 1'b1, '{1'b1, 9'd5, 8'd6, 16'h0000}},
    '{4'd8, 8'd255, 8'd255, 16'hFFFF, 16'h0000, 1'b1, NoWrite},
    '{4'd8, 8'd254, 8'd200, 16'hABCD, 16'h0000, 1'b1, '{1'b1, 9'd254, 8'd200, 16'hABCD}},
    '{4'd9, 8'd0, 8'd0, 16'hFFFF, 16'h0000, 1'b1, NoWrite},
    '{4'd10, 8'd255, 8'd255, 16'hFFFF, 16'h0000, 1'b0, NoWrite},
    '{4'd11, 8'd4, 8'd5, 16'h8410, 16'h7BEF, 1'b0, NoWrite},
    '{4'd11, 8'd5, 8'd5, 16'h8410, 16'h7BEF, 1'b0, NoWrite}
  };

  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        cfg_wr_en_i      = 1'b0;
  cfg_reg_e    cfg_idx_i        = CFG_SPRITE_POS_X;
  logic [15:0] cfg_data_i       = '0;
  logic        in_valid_i       = 1'b0;
  logic        in_ready_o;
  logic [7:0]  local_x_i        = '0;
  logic [7:0]  local_y_i        = '0;
  logic [15:0] texel_color_i    = '0;
  logic [15:0] backdrop_color_i = '0;
  logic        out_valid_o;
  logic        out_ready_i      = 1'b0;
  logic        write_enable_o;
  logic [8:0]  screen_col_o;
  logic [7:0]  screen_row_o;
  logic [15:0] out_color_o;

  sprite_pixel_alpha_compositor_core u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_wr_en_i      (cfg_wr_en_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .local_x_i        (local_x_i),
    .local_y_i        (local_y_i),
    .texel_color_i    (texel_color_i),
    .backdrop_color_i (backdrop_color_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .write_enable_o   (write_enable_o),
    .screen_col_o     (screen_col_o),
    .screen_row_o     (screen_row_o),
    .out_color_o      (out_color_o)
  );

  // Our own copy of the registers, kept in step with every write we make.
  sprite_setting_t cur_cfg = DirSettings[0];

  // Pixels still owed by the block, oldest first.
  pixel_write_t pending_writes [$];

  // Percentage of cycles in which the request side holds back, and in which
  // the result side refuses to take a result.
  int unsigned src_idle_pct  = 34;
  int unsigned sink_idle_pct = 66;

  int unsigned mismatches      = 0;
  int unsigned requests_sent   = 0;
  int unsigned results_checked = 0;
  int unsigned pixels_written  = 0;
  int unsigned settings_used   = 1;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Blends one colour channel; the caller truncates to the channel width.
  function automatic int unsigned blend_channel(int unsigned fg_c, int unsigned bg_c,
                                                int unsigned a);
    return (fg_c * a + bg_c * (255 - a)) >> 8;
  endfunction

  // Works out the write that one texel causes under a given setting.
  function automatic pixel_write_t composite_texel(sprite_setting_t c, logic [7:0] lx,
                                                   logic [7:0] ly, logic [15:0] fg,
                                                   logic [15:0] bg);
    int                 px, py, w, h, col, row;
    logic signed [15:0] sx, sy;
    int unsigned        a, r, g, b;
    bit                 rejected, we;
    logic [15:0]        color;
    px = int'($signed(c.pos_x));
    py = int'($signed(c.pos_y));
    w  = int'(c.width);
    h  = int'(c.height);
    // Rejection looks at the world position only, before the camera moves it.
    rejected = (px < -w) || (px > ScrW) || (py < -h) || (py > ScrH);
    // The camera-adjusted origin wraps in 16 bits; the texel offset does not.
    sx  = c.pos_x - c.view_x;
    sy  = c.pos_y - c.view_y;
    col = int'(sx) + int'(lx);
    row = int'(sy) + int'(ly);
    we  = !rejected && (int'(lx) < w) && (int'(ly) < h) &&
          (col >= 0) && (col < ScrW) && (row >= 0) && (row < ScrH);
    // Black counts as see-through only when the sprite is fully opaque.
    if (fg == '0 && c.alpha == OpaqueAlpha) we = 1'b0;
    color = fg;
    if (we && c.alpha != OpaqueAlpha && c.blend) begin
      a = c.alpha;
      r = blend_channel(fg[15:11], bg[15:11], a);
      g = blend_channel(fg[10:5], bg[10:5], a);
      b = blend_channel(fg[4:0], bg[4:0], a);
      color = {5'(r), 6'(g), 5'(b)};
    end
    if (!we) return NoWrite;
    return '{1'b1, 9'(col), 8'(row), color};
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH at %0t ns: %s is 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // One register write; the enable stays high if another write follows
  // straight away, and is lowered by apply_setting once all are done.
  task automatic write_reg(cfg_reg_e idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_wr_en_i <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    case (idx)
      CFG_SPRITE_POS_X:  cur_cfg.pos_x  = data;
      CFG_SPRITE_POS_Y:  cur_cfg.pos_y  = data;
      CFG_VIEW_OFFSET_X: cur_cfg.view_x = data;
      CFG_VIEW_OFFSET_Y: cur_cfg.view_y = data;
      CFG_SPRITE_WIDTH:  cur_cfg.width  = data[7:0];
      CFG_SPRITE_HEIGHT: cur_cfg.height = data[7:0];
      CFG_OPACITY:       cur_cfg.alpha  = data[7:0];
      CFG_BLEND_ENABLE:  cur_cfg.blend  = data[0];
      default: ;
    endcase
  endtask

  // Loads a whole setting. Only called while the pipeline is empty.
  task automatic apply_setting(sprite_setting_t s);
    write_reg(CFG_SPRITE_POS_X, s.pos_x);
    write_reg(CFG_SPRITE_POS_Y, s.pos_y);
    write_reg(CFG_VIEW_OFFSET_X, s.view_x);
    write_reg(CFG_VIEW_OFFSET_Y, s.view_y);
    write_reg(CFG_SPRITE_WIDTH, {8'h00, s.width});
    write_reg(CFG_SPRITE_HEIGHT, {8'h00, s.height});
    write_reg(CFG_OPACITY, {8'h00, s.alpha});
    write_reg(CFG_BLEND_ENABLE, {15'd0, s.blend});
    @(negedge clk_i);
    cfg_wr_en_i <= 1'b0;
    settings_used++;
  endtask

  // Offers one texel request, with random hold-off before it, and records the
  // pixel it must produce once the block has taken it. Each falling edge sees
  // exactly one assignment to the valid, so a back-to-back request keeps the
  // valid high without a glitch.
  task automatic send_texel(logic [7:0] lx, logic [7:0] ly, logic [15:0] fg,
                            logic [15:0] bg, bit given, pixel_write_t given_px);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    local_x_i        <= lx;
    local_y_i        <= ly;
    texel_color_i    <= fg;
    backdrop_color_i <= bg;
    do @(posedge clk_i); while (!in_ready_o);
    pending_writes.push_back(given ? given_px : composite_texel(cur_cfg, lx, ly, fg, bg));
    requests_sent++;
  endtask

  // Stops offering requests and waits until the pipeline has drained.
  task automatic finish_batch();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Most random settings place a sprite of modest size near the screen with a
  // small camera offset, so that plenty of pixels are really written; the rest
  // are arbitrary register values, which mostly end in rejection.
  function automatic sprite_setting_t random_setting();
    sprite_setting_t s;
    int              w, h;
    if ($urandom_range(0, 3) == 0) begin
      s.pos_x  = 16'($urandom);
      s.pos_y  = 16'($urandom);
      s.view_x = 16'($urandom);
      s.view_y = 16'($urandom);
      s.width  = 8'($urandom);
      s.height = 8'($urandom);
      s.alpha  = 8'($urandom);
      s.blend  = 1'($urandom);
    end else begin
      w = ($urandom_range(0, 9) == 0) ? 255 : int'($urandom_range(1, 48));
      h = ($urandom_range(0, 9) == 0) ? 255 : int'($urandom_range(1, 48));
      s.width  = 8'(w);
      s.height = 8'(h);
      s.pos_x  = 16'(int'($urandom_range(0, ScrW + w)) - w);
      s.pos_y  = 16'(int'($urandom_range(0, ScrH + h)) - h);
      s.view_x = 16'(int'($urandom_range(0, 96)) - 48);
      s.view_y = 16'(int'($urandom_range(0, 96)) - 48);
      case ($urandom_range(0, 3))
        0:       s.alpha = OpaqueAlpha;
        1:       s.alpha = 8'd0;
        default: s.alpha = 8'($urandom);
      endcase
      s.blend = 1'($urandom_range(0, 1));
    end
    return s;
  endfunction

  // Random texels: mostly inside the sprite's own box, some anywhere, with
  // black and white texels mixed in on purpose.
  task automatic send_random_texels(int count);
    int          wmax, hmax;
    logic [7:0]  lx, ly;
    logic [15:0] fg;
    wmax = cur_cfg.width;
    hmax = cur_cfg.height;
    if (wmax > 0) wmax--;
    if (hmax > 0) hmax--;
    for (int i = 0; i < count; i++) begin
      lx = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, wmax)) : 8'($urandom);
      ly = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, hmax)) : 8'($urandom);
      case ($urandom_range(0, 9))
        0:       fg = 16'h0000;
        1:       fg = 16'hFFFF;
        default: fg = 16'($urandom);
      endcase
      send_texel(lx, ly, fg, 16'($urandom), 1'b0, NoWrite);
    end
  endtask

  // The result side refuses results at random, at the rate of the current phase.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  // Every result taken is compared field by field with the oldest pixel owed.
  always @(posedge clk_i) begin : result_check
    pixel_write_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_checked++;
      if (write_enable_o) pixels_written++;
      if (pending_writes.size() == 0) begin
        report_mismatch("result with no request outstanding, write enable",
                        32'(write_enable_o), 32'd0);
      end else begin
        want = pending_writes.pop_front();
        if (write_enable_o !== want.we)
          report_mismatch("write enable", 32'(write_enable_o), 32'(want.we));
        if (screen_col_o !== want.col)
          report_mismatch("screen column", 32'(screen_col_o), 32'(want.col));
        if (screen_row_o !== want.row)
          report_mismatch("screen row", 32'(screen_row_o), 32'(want.row));
        if (out_color_o !== want.color)
          report_mismatch("colour", 32'(out_color_o), 32'(want.color));
      end
    end
  end

  // Ends the run if neither channel moves for too long.
  initial begin : watchdog
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("sprite_pixel_alpha_compositor_core test failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned cur_setting;
    // Reset is held from time zero and released on a falling edge.
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table. The first rows run on the reset values; a change of
    // setting drains the pipeline before the registers are touched.
    cur_setting = 0;
    foreach (DirCases[i]) begin
      if (DirCases[i].setting != cur_setting) begin
        finish_batch();
        cur_setting = DirCases[i].setting;
        apply_setting(DirSettings[cur_setting]);
      end
      send_texel(DirCases[i].lx, DirCases[i].ly, DirCases[i].fg, DirCases[i].bg,
                 DirCases[i].known, DirCases[i].want);
    end
    finish_batch();

    // Random part in three pacing phases: slow receiver, slow sender, then
    // both flat out. Each phase runs four batches, each under a fresh setting.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin src_idle_pct = 34; sink_idle_pct = 66; end
        1:       begin src_idle_pct = 66; sink_idle_pct = 34; end
        default: begin src_idle_pct = 0;  sink_idle_pct = 0;  end
      endcase
      for (int batch = 0; batch < 4; batch++) begin
        apply_setting(random_setting());
        send_random_texels(46);
        finish_batch();
      end
    end

    $display("Summary: %0d texel requests under %0d register settings and three pacing phases,",
             requests_sent, settings_used);
    $display("Summary: %0d results compared, %0d of them pixel writes.",
             results_checked, pixels_written);
    if (mismatches == 0 && pending_writes.size() == 0) begin
      $display("sprite_pixel_alpha_compositor_core test passed");
    end else begin
      $display("sprite_pixel_alpha_compositor_core test failed");
    end
    $finish;
  end

endmodule

>>> sprite_pixel_alpha_compositor_core.f
design/spac_pkg.sv
design/sprite_pixel_alpha_compositor_core.sv
design/spac_checker.sv
bench/sprite_pixel_alpha_compositor_core_tb.sv
